// ===== rtl/supg_pkg.sv =====
// Shared constants and types for the upwind diffusivity block.
package supg_pkg;

  localparam int MAX_DIMS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;
  localparam int DIV_W         = 64;
  localparam int INT_FRAC      = 24;
  localparam int CF_TERMS      = 40;
  localparam int SUM_CLAMP_BITS = 34;
  localparam int ISQRT_SHIFT   = 30;
  localparam logic [28:0] ISQRT15_Q30 = 29'd277238947;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_ASYM  = 2'd1;
  localparam logic [1:0] MODE_CRIT  = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_DIM  = 2'd2;

  typedef struct packed {
    logic        start;
    logic        active;
    logic [1:0]  mode;
    logic [30:0] k;
  } lane_ctl_t;

endpackage

// ===== rtl/supg_upwind_diffusivity_top.sv =====
// Top level: config registers, peak tracking, axis lanes and merge stage.
//
//  channel  signals                                   dir  word
//  in       in_valid/in_ready, vel_*, len_*, avg_*    in   one mesh element
//  out      out_valid/out_ready, upwind_*, peak_*     out  one result
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in   one register write
//
// One element at a time; lanes run in parallel, one per axis. The exact rule up to Peclet 20
// is the worst case (41 divides); other paths use one reciprocal divide or no second divide,
// and an inactive lane just loads a zero term. Merge registers the clamped sum, the product
// and the result in turn. Next word accepted in the same cycle the result is raised.
// cfg_ready is always high. Reset is synchronous.
// A waiting result does not block the next element; a new result waits.
module supg_upwind_diffusivity_top import supg_pkg::*; #(
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [30:0] len_x,
  input  logic [30:0] len_y,
  input  logic [30:0] len_z,
  input  logic signed [31:0] avg_diffusivity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] upwind_diffusivity,
  output logic signed [31:0] peak_diffusivity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int SW = 64 + 2;
  localparam logic [SW-1:0] SUM_CLAMP = SW'(1) << SUM_CLAMP_BITS;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_RUN  = 4'b0010,
    T_MUL  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t   state;
  logic [1:0]   upwind_mode;
  logic [30:0]  min_diffusivity;
  logic [1:0]   dim_count;
  logic signed [31:0] max_diffusivity;
  logic signed [31:0] peak_hold;
  logic [SUM_CLAMP_BITS:0] sclamp;
  logic [63:0]  prod;

  logic         accept;
  logic [30:0]  kmin;
  logic [30:0]  k_eff;
  logic [1:0]   axes;
  logic [31:0]  vel_a [NUM_AXES];
  logic [30:0]  len_a [NUM_AXES];
  lane_ctl_t    ctl [MAX_DIMS];
  logic [63:0]  term [MAX_DIMS];
  logic [MAX_DIMS-1:0] lane_done;
  logic [SW-1:0] sum;
  logic [63:0]  rnd;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;

  assign kmin  = (min_diffusivity == '0) ? 31'd1 : min_diffusivity;
  assign k_eff = (avg_diffusivity < $signed({1'b0, kmin})) ? kmin : avg_diffusivity[30:0];
  assign axes  = (dim_count > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dim_count;

  assign vel_a[0] = vel_x;
  assign vel_a[1] = vel_y;
  assign vel_a[2] = vel_z;
  assign len_a[0] = len_x;
  assign len_a[1] = len_y;
  assign len_a[2] = len_z;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    assign ctl[i].start  = accept;
    assign ctl[i].active = (2'(i) < axes);
    assign ctl[i].mode   = upwind_mode;
    assign ctl[i].k      = k_eff;

    supg_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[i]),
      .vel  (vel_a[i]),
      .len  (len_a[i]),
      .done (lane_done[i]),
      .term (term[i])
    );
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sum = sum + SW'(term[i]);
    end
  end

  assign rnd = (prod + (64'd1 << (ISQRT_SHIFT - 1))) >> ISQRT_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      upwind_mode     <= MODE_EXACT;
      min_diffusivity <= 31'd1;
      dim_count       <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: upwind_mode     <= cfg_data[1:0];
        REG_MIN:  min_diffusivity <= cfg_data;
        REG_DIM:  dim_count       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      max_diffusivity <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != T_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            if (avg_diffusivity > max_diffusivity) begin
              max_diffusivity <= avg_diffusivity;
              peak_hold       <= avg_diffusivity;
            end else begin
              peak_hold <= max_diffusivity;
            end
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (&lane_done) begin
            sclamp <= (sum > SUM_CLAMP) ? SUM_CLAMP[SUM_CLAMP_BITS:0] : sum[SUM_CLAMP_BITS:0];
            state  <= T_MUL;
          end
        end
        T_MUL: begin
          prod  <= 64'(sclamp) * 64'(ISQRT15_Q30);
          state <= T_OUT;
        end
        T_OUT: begin
          if (!out_valid || out_ready) begin
            upwind_diffusivity <= (rnd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rnd[31:0]);
            peak_diffusivity   <= peak_hold;
            out_valid          <= 1'b1;
            state              <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_out_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == T_OUT))
    else $error("result raised outside merge stage");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> max_diffusivity >= $past(max_diffusivity))
    else $error("peak diffusivity decreased");

  a_result_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !upwind_diffusivity[31])
    else $error("negative upwind diffusivity");

  a_run_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == T_RUN)
    else $error("element accepted without starting lanes");

endmodule

// ===== rtl/supg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module supg_div import supg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W - 1);
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/supg_lane.sv =====
// One axis lane: Peclet number, upwind coordinate and per-axis term.
module supg_lane import supg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  lane_ctl_t   ctl,
  input  logic [31:0] vel,
  input  logic [30:0] len,
  output logic        done,
  output logic [63:0] term
);

  localparam int XW     = FRAC_BITS + 1;
  localparam int IF_SH  = INT_FRAC - FRAC_BITS;
  localparam int CNTW   = $clog2(CF_TERMS);
  localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO_F    = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] ASYM_LIM = ONE * 64'd3;
  localparam logic [63:0] BIG_LIM  = ONE * 64'd20;
  localparam logic [63:0] CF_D0    = 64'(2 * CF_TERMS + 1) << INT_FRAC;
  localparam logic [63:0] RND      = (IF_SH == 0) ? 64'd0 : (64'd1 << (IF_SH - 1));
  // ceil(2^32 / 3): floor(x / 3) is exact for x below 2^31
  localparam logic [63:0] RECIP3   = 64'd1431655766;
  localparam logic [XW-1:0] ONE_X  = XW'(1) << FRAC_BITS;
  localparam logic [CNTW-1:0] CF_LAST = CNTW'(CF_TERMS - 1);

  typedef enum logic [10:0] {
    L_IDLE = 11'b00000000001,
    L_MUL  = 11'b00000000010,
    L_PDIV = 11'b00000000100,
    L_SEL  = 11'b00000001000,
    L_XDIV = 11'b00000010000,
    L_SQ   = 11'b00000100000,
    L_CF   = 11'b00001000000,
    L_FIN  = 11'b00010000000,
    L_T1   = 11'b00100000000,
    L_T2   = 11'b01000000000,
    L_DONE = 11'b10000000000
  } lane_state_t;

  lane_state_t     state;
  logic            vneg;
  logic [31:0]     vmag;
  logic [30:0]     h;
  logic [30:0]     kk;
  logic [1:0]      mode;
  logic [63:0]     amag;
  logic [XW-1:0]   xmag;
  logic [28:0]     a24;
  logic [32:0]     a2;
  logic [32:0]     m;
  logic [CNTW-1:0] cnt;
  logic [63:0]     dvd;
  logic [63:0]     dsr;
  logic            go;
  logic            div_done;
  logic [63:0]     q;
  logic            neg;
  logic [63:0]     sq;
  logic [63:0]     d_new;

  supg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (go),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (q)
  );

  assign neg   = vneg && (amag != '0);
  assign sq    = 64'(a24) * 64'(a24);
  assign d_new = (64'({cnt, 1'b1}) << INT_FRAC) + q;
  assign done  = (state == L_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      case (state)
        L_IDLE, L_DONE: begin
          if (ctl.start) begin
            if (ctl.active) begin
              vneg  <= vel[31];
              vmag  <= vel[31] ? 32'(-vel) : vel;
              h     <= len;
              kk    <= ctl.k;
              mode  <= ctl.mode;
              state <= L_MUL;
            end else begin
              term  <= '0;
              state <= L_DONE;
            end
          end
        end
        L_MUL: begin
          dvd   <= 64'(vmag) * 64'(h);
          dsr   <= 64'({kk, 1'b0});
          go    <= 1'b1;
          state <= L_PDIV;
        end
        L_PDIV: begin
          if (div_done) begin
            amag  <= q;
            state <= L_SEL;
          end
        end
        L_SEL: begin
          case (mode)
            MODE_ASYM: begin
              if (amag > ASYM_LIM) begin
                xmag  <= ONE_X;
              end else begin
                xmag  <= XW'((64'(amag[31:0]) * RECIP3) >> 32);
              end
              state <= L_T1;
            end
            MODE_CRIT: begin
              if (amag < ONE || (amag == ONE && !neg)) begin
                xmag  <= '0;
                state <= L_T1;
              end else begin
                dvd   <= TWO_F;
                dsr   <= amag;
                go    <= 1'b1;
                state <= L_XDIV;
              end
            end
            default: begin
              if (amag == '0) begin
                xmag  <= '0;
                state <= L_T1;
              end else if (amag > BIG_LIM) begin
                dvd   <= TWO_F;
                dsr   <= amag;
                go    <= 1'b1;
                state <= L_XDIV;
              end else begin
                a24   <= 29'(amag << IF_SH);
                state <= L_SQ;
              end
            end
          endcase
        end
        L_XDIV: begin
          if (div_done) begin
            xmag  <= XW'(ONE - q);
            state <= L_T1;
          end
        end
        L_SQ: begin
          a2    <= 33'(sq >> INT_FRAC);
          dvd   <= (sq >> INT_FRAC) << INT_FRAC;
          dsr   <= CF_D0;
          cnt   <= CF_LAST;
          go    <= 1'b1;
          state <= L_CF;
        end
        L_CF: begin
          if (div_done) begin
            dsr <= d_new;
            go  <= 1'b1;
            if (cnt == CNTW'(1)) begin
              dvd   <= 64'(a24) << INT_FRAC;
              state <= L_FIN;
            end else begin
              dvd <= 64'(a2) << INT_FRAC;
              cnt <= cnt - 1'b1;
            end
          end
        end
        L_FIN: begin
          if (div_done) begin
            xmag  <= XW'((q + RND) >> IF_SH);
            state <= L_T1;
          end
        end
        L_T1: begin
          m     <= 33'((64'(xmag) * 64'(vmag)) >> FRAC_BITS);
          state <= L_T2;
        end
        L_T2: begin
          term  <= (64'(m) * 64'(h)) >> FRAC_BITS;
          state <= L_DONE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
